[sv/gii8_pkg.sv]
// Shared types, constants and gradient helper for the gradient integral image block.
package gii8_pkg;

    localparam int NCH     = 8;
    localparam int SUM_W   = 30;
    localparam int ABS_W   = 29;
    localparam int GRAD_W  = 10;
    localparam int COL_W   = 12;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;
    localparam int NJOB    = 3;
    localparam int TDATA_W = 240;

    // job kinds, in issue order
    localparam int JOB_UP        = 0;
    localparam int JOB_LAST_PREV = 1;
    localparam int JOB_LAST_END  = 2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef logic signed [GRAD_W-1:0] grad_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [NCH-1:0][SUM_W-1:0] line_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        grad_t            dx;
        grad_t            dy;
        logic             first_row;
        logic             last_set;
        logic             frame_end;
    } job_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } q_status_t;

    function automatic grad_t grad(input logic [7:0] a, input logic [7:0] b,
                                   input logic dbl);
        grad_t d;
        d = {2'b00, a} - {2'b00, b};
        return dbl ? grad_t'(d <<< 1) : d;
    endfunction

endpackage

[sv/gii8_front.sv]
// Front end: pixel line stores, column window and gradient job generation.
module gii8_front
    import gii8_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    pixel,
    input  logic                          restart,
    input  logic [$clog2(MAX_WIDTH)-1:0]  col_last,
    input  logic [$clog2(MAX_HEIGHT)-1:0] row_last,
    output logic                          q_push,
    output job_t                          q_job,
    input  q_status_t                     q_stat
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [7:0] mem0 [MAX_WIDTH];
    logic [7:0] mem1 [MAX_WIDTH];

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          s1_valid_reg;
    logic [NJOB-1:0] done_reg;

    logic [7:0]    p0_reg, rda0_reg, rda1_reg, rdb0_reg, rdb1_reg;
    logic [CW-1:0] c_reg;
    logic          r_odd_reg, f_r0_reg, f_r1_reg, f_rl_reg, c_last_reg;
    logic [7:0]    hist_cur [1:2];
    logic [7:0]    hist_up1;

    logic          acc, item_done;
    logic [CW-1:0] col_ahead;
    logic [7:0]    up_c, up_n, up2_c;
    logic          c_is0, c_is1;
    logic [NJOB-1:0] need, pending, sel, remaining;
    job_t          jobs [NJOB];

    assign acc       = s_tvalid && s_tready;
    assign col_ahead = col_reg + CW'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_reg == col_last)
        begin
            col_next = '0;
            row_next = (row_reg == row_last) ? '0 : row_reg + RW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rda0_reg <= mem0[col_reg];
            rda1_reg <= mem1[col_reg];
            rdb0_reg <= mem0[col_ahead];
            rdb1_reg <= mem1[col_ahead];
            if (row_reg[0])
                mem1[col_reg] <= pixel;
            else
                mem0[col_reg] <= pixel;
            p0_reg     <= pixel;
            c_reg      <= col_reg;
            r_odd_reg  <= row_reg[0];
            f_r0_reg   <= (row_reg == '0);
            f_r1_reg   <= (row_reg == RW'(1));
            f_rl_reg   <= (row_reg == row_last);
            c_last_reg <= (col_reg == col_last);
        end
        if (item_done)
        begin
            hist_cur[2] <= hist_cur[1];
            hist_cur[1] <= p0_reg;
            hist_up1    <= up_c;
        end
    end

    assign up_c  = r_odd_reg ? rda0_reg : rda1_reg;
    assign up_n  = r_odd_reg ? rdb0_reg : rdb1_reg;
    assign up2_c = r_odd_reg ? rda1_reg : rda0_reg;
    assign c_is0 = (c_reg == '0);
    assign c_is1 = (c_reg == CW'(1));

    always_comb
    begin
        need = '0;
        need[JOB_UP]        = !f_r0_reg;
        need[JOB_LAST_PREV] = f_rl_reg && !c_is0;
        need[JOB_LAST_END]  = f_rl_reg && c_last_reg;

        jobs[JOB_UP].col       = COL_W'(c_reg);
        jobs[JOB_UP].dx        = c_is0      ? grad(up_n, up_c, 1'b1)
                               : c_last_reg ? grad(up_c, hist_up1, 1'b1)
                                            : grad(up_n, hist_up1, 1'b0);
        jobs[JOB_UP].dy        = f_r1_reg ? grad(p0_reg, up_c, 1'b1)
                                          : grad(p0_reg, up2_c, 1'b0);
        jobs[JOB_UP].first_row = f_r1_reg;
        jobs[JOB_UP].last_set  = 1'b0;
        jobs[JOB_UP].frame_end = 1'b0;

        jobs[JOB_LAST_PREV].col       = COL_W'(c_reg - CW'(1));
        jobs[JOB_LAST_PREV].dx        = c_is1 ? grad(p0_reg, hist_cur[1], 1'b1)
                                              : grad(p0_reg, hist_cur[2], 1'b0);
        jobs[JOB_LAST_PREV].dy        = grad(hist_cur[1], hist_up1, 1'b1);
        jobs[JOB_LAST_PREV].first_row = 1'b0;
        jobs[JOB_LAST_PREV].last_set  = 1'b1;
        jobs[JOB_LAST_PREV].frame_end = 1'b0;

        jobs[JOB_LAST_END].col       = COL_W'(c_reg);
        jobs[JOB_LAST_END].dx        = grad(p0_reg, hist_cur[1], 1'b1);
        jobs[JOB_LAST_END].dy        = grad(p0_reg, up_c, 1'b1);
        jobs[JOB_LAST_END].first_row = 1'b0;
        jobs[JOB_LAST_END].last_set  = 1'b1;
        jobs[JOB_LAST_END].frame_end = 1'b1;
    end

    always_comb
    begin
        pending = s1_valid_reg ? (need & ~done_reg) : '0;
        sel     = '0;
        q_job   = jobs[0];
        for (int k = NJOB - 1; k >= 0; k--)
        begin
            if (pending[k])
            begin
                sel   = NJOB'(1) << k;
                q_job = jobs[k];
            end
        end
        q_push    = (pending != '0) && q_stat.not_full;
        remaining = pending & ~sel;
        item_done = s1_valid_reg && ((pending == '0) || (q_push && remaining == '0));
        s_tready  = !s1_valid_reg || item_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= '0;
        end
        else
        begin
            if (acc)
                s1_valid_reg <= 1'b1;
            else if (item_done)
                s1_valid_reg <= 1'b0;
            if (item_done)
                done_reg <= '0;
            else if (q_push)
                done_reg <= done_reg | sel;
        end
    end

endmodule

[sv/gii8_queue.sv]
// Short job queue between the front end and the accumulation back end.
module gii8_queue
    import gii8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head,
    output q_status_t stat
);

    job_t           slots [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg;

    assign head          = slots[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.not_full  = (count_reg != (QAW+1)'(QDEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + (QAW+1)'(1);
                2'b01:   count_reg <= count_reg - (QAW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[sv/gii8_back.sv]
// Back end: channel split, row running sums, integral line store and output register.
module gii8_back
    import gii8_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  job_t               head,
    input  q_status_t          q_stat,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);

    line_t mem [MAX_WIDTH];

    sum_t          run_reg [2][NCH];
    logic          b1_valid_reg, out_valid_reg;
    logic [CW-1:0] b1_col_reg;
    logic          b1_first_reg, b1_fe_reg, hazard_reg;
    line_t         b1_run_reg, rd_reg, last_wr_reg, out_reg;
    logic          out_last_reg;

    logic          b1_adv;
    grad_t         ax, ay;
    grad_t         v [NCH];
    sum_t          run_new [NCH];
    line_t         above, sum;
    logic          set;

    assign b1_adv = b1_valid_reg && (!out_valid_reg || m_tready);
    assign q_pop  = q_stat.not_empty && (!b1_valid_reg || b1_adv);
    assign set    = head.last_set;

    always_comb
    begin
        ax   = head.dx[GRAD_W-1] ? -head.dx : head.dx;
        ay   = head.dy[GRAD_W-1] ? -head.dy : head.dy;
        v[0] = head.dy[GRAD_W-1] ? '0 : head.dx;
        v[1] = head.dy[GRAD_W-1] ? '0 : ax;
        v[2] = head.dy[GRAD_W-1] ? head.dx : '0;
        v[3] = head.dy[GRAD_W-1] ? ax : '0;
        v[4] = head.dx[GRAD_W-1] ? '0 : head.dy;
        v[5] = head.dx[GRAD_W-1] ? '0 : ay;
        v[6] = head.dx[GRAD_W-1] ? head.dy : '0;
        v[7] = head.dx[GRAD_W-1] ? ay : '0;
        for (int k = 0; k < NCH; k++)
        begin
            run_new[k] = ((head.col == '0) ? '0 : run_reg[set][k])
                       + SUM_W'(signed'(v[k]));
        end
        for (int k = 0; k < NCH; k++)
        begin
            above[k] = b1_first_reg ? '0 : (hazard_reg ? last_wr_reg[k] : rd_reg[k]);
            sum[k]   = above[k] + b1_run_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < 2; s++)
                for (int k = 0; k < NCH; k++)
                    run_reg[s][k] <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                b1_valid_reg <= 1'b1;
                for (int k = 0; k < NCH; k++)
                    run_reg[set][k] <= run_new[k];
            end
            else if (b1_adv)
            begin
                b1_valid_reg <= 1'b0;
            end
            if (b1_adv)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_adv)
        begin
            mem[b1_col_reg] <= sum;
            last_wr_reg     <= sum;
            out_reg         <= sum;
            out_last_reg    <= b1_fe_reg;
        end
        if (q_pop)
        begin
            rd_reg       <= mem[head.col[CW-1:0]];
            hazard_reg   <= b1_adv && (b1_col_reg == head.col[CW-1:0]);
            b1_col_reg   <= head.col[CW-1:0];
            b1_first_reg <= head.first_row;
            b1_fe_reg    <= head.frame_end;
            for (int k = 0; k < NCH; k++)
                b1_run_reg[k] <= run_new[k];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000,
                       out_reg[7][ABS_W-1:0], out_reg[6],
                       out_reg[5][ABS_W-1:0], out_reg[4],
                       out_reg[3][ABS_W-1:0], out_reg[2],
                       out_reg[1][ABS_W-1:0], out_reg[0]};

endmodule

[sv/gradient_integral_image_8ch.sv]
// Top level of the eight-channel sign-split gradient integral image.
//
//  channel  direction  handshake               payload
//  s_       in         s_tvalid / s_tready     s_tdata: pixel
//  m_       out        m_tvalid / m_tready     m_tdata: eight sums, m_tlast: frame end
//  cfg_     in         cfg_we                  cfg_index, cfg_data
//
// One pixel a cycle unless the job queue or output stalls; a pixel whose column yields more
// than one word issues them one at a time via the front end's single job issue slot (last
// row: two words a pixel past column zero, three at its final pixel). Words pass through
// front window, queue and line store read to the output register. Reset clears positions,
// running sums and all valid flags. Either side may stall; the job queue buffers four words.
module gradient_integral_image_8ch
    import gii8_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,  // [7:0] pixel
    output logic               m_tvalid,
    input  logic               m_tready,
    // [29:0] sum_dx_dy_nonneg, [58:30] sum_absdx_dy_nonneg, [88:59] sum_dx_dy_neg,
    // [117:89] sum_absdx_dy_neg, [147:118] sum_dy_dx_nonneg, [176:148] sum_absdy_dx_nonneg,
    // [206:177] sum_dy_dx_neg, [235:207] sum_absdy_dx_neg, [239:236] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [10:0]        cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int W_RST = (1024 < MAX_WIDTH) ? 1024 : MAX_WIDTH;
    localparam int H_RST = (1024 < MAX_HEIGHT) ? 1024 : MAX_HEIGHT;

    logic [CW-1:0] wlast_reg;
    logic [RW-1:0] hlast_reg;
    logic [13:0]   v14;
    logic [CW-1:0] wlast_next;
    logic [RW-1:0] hlast_next;

    logic      q_push, q_pop;
    job_t      q_job, q_head;
    q_status_t q_stat;

    assign v14 = {3'b000, cfg_data};

    always_comb
    begin
        priority if (v14 < 14'd2)
            wlast_next = CW'(1);
        else if (v14 > 14'(MAX_WIDTH))
            wlast_next = CW'(MAX_WIDTH - 1);
        else
            wlast_next = CW'(v14 - 14'd1);
        priority if (v14 < 14'd2)
            hlast_next = RW'(1);
        else if (v14 > 14'(MAX_HEIGHT))
            hlast_next = RW'(MAX_HEIGHT - 1);
        else
            hlast_next = RW'(v14 - 14'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg <= CW'(W_RST - 1);
            hlast_reg <= RW'(H_RST - 1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_WIDTH)
                wlast_reg <= wlast_next;
            else if (cfg_index == CFG_HEIGHT)
                hlast_reg <= hlast_next;
        end
    end

    gii8_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .pixel    (s_tdata),
        .restart  (cfg_we),
        .col_last (wlast_reg),
        .row_last (hlast_reg),
        .q_push   (q_push),
        .q_job    (q_job),
        .q_stat   (q_stat)
    );

    gii8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    gii8_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_stat.not_full)
        else $error("job pushed into full queue");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.not_empty)
        else $error("job popped from empty queue");

    a_end_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_job.frame_end) |-> (q_job.last_set && !q_job.first_row))
        else $error("frame end job outside last row");

endmodule

[dv/tb.sv]
// Testbench for the eight-channel gradient integral image: predicts every word and checks it.
module tb;
    import gii8_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SIZE_MAX     = 1024;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 24;
    localparam int ITEMS        = 220;

    typedef struct {
        logic [SUM_W-1:0] sums [NCH];
        logic             last;
    } sums_word_t;

    class integral_tracker;
        int unsigned      width_reg;
        int unsigned      height_reg;
        logic [7:0]       lines [2][SIZE_MAX];
        logic [SUM_W-1:0] col_integral [SIZE_MAX][NCH];
        logic [SUM_W-1:0] run_sums [2][NCH];
        int unsigned      row;
        int unsigned      col;
        sums_word_t       pending_sums [$];
        int               errors;

        function new();
            width_reg  = SIZE_MAX;
            height_reg = SIZE_MAX;
            row        = 0;
            col        = 0;
            errors     = 0;
            foreach (lines[i, j]) lines[i][j] = '0;
            foreach (col_integral[i, j]) col_integral[i][j] = '0;
            foreach (run_sums[i, j]) run_sums[i][j] = '0;
        endfunction

        function void write_reg(logic idx, logic [10:0] value);
            if (idx == CFG_WIDTH) width_reg = value;
            else height_reg = value;
            row = 0;
            col = 0;
        endfunction

        function int unsigned clamp(int unsigned v);
            if (v < 2) return 2;
            if (v > SIZE_MAX) return SIZE_MAX;
            return v;
        endfunction

        function int px(int unsigned r, int unsigned c);
            return int'(lines[r & 1][c]);
        endfunction

        function void accumulate(int unsigned r, int unsigned c, int dx, int dy,
                                 int set, logic last);
            int         v [NCH];
            int         ax;
            int         ay;
            sums_word_t w;
            logic [SUM_W-1:0] above;
            logic [SUM_W-1:0] total;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            v[0] = dy >= 0 ? dx : 0;
            v[1] = dy >= 0 ? ax : 0;
            v[2] = dy < 0 ? dx : 0;
            v[3] = dy < 0 ? ax : 0;
            v[4] = dx >= 0 ? dy : 0;
            v[5] = dx >= 0 ? ay : 0;
            v[6] = dx < 0 ? dy : 0;
            v[7] = dx < 0 ? ay : 0;
            for (int k = 0; k < NCH; k++)
            begin
                if (c == 0) run_sums[set][k] = '0;
                run_sums[set][k] = run_sums[set][k] + SUM_W'(v[k]);
                above = (r == 0) ? '0 : col_integral[c][k];
                total = above + run_sums[set][k];
                col_integral[c][k] = total;
                w.sums[k] = (k & 1) ? {1'b0, total[ABS_W-1:0]} : total;
            end
            w.last = last;
            pending_sums = {pending_sums, w};
        endfunction

        function void take_pixel(logic [7:0] pixel);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            int          p;
            int          dx;
            int          dy;
            w = clamp(width_reg);
            h = clamp(height_reg);
            r = row;
            c = col;
            p = int'(pixel);
            if (r >= h || c >= w)
            begin
                r = 0;
                c = 0;
            end
            if (r >= 1)
            begin
                if (c == 0) dx = (px(r - 1, 1) - px(r - 1, 0)) * 2;
                else if (c == w - 1) dx = (px(r - 1, c) - px(r - 1, c - 1)) * 2;
                else dx = px(r - 1, c + 1) - px(r - 1, c - 1);
                if (r == 1) dy = (p - px(r - 1, c)) * 2;
                else dy = p - px(r, c);
                accumulate(r - 1, c, dx, dy, 0, 1'b0);
            end
            lines[r & 1][c] = pixel;
            if (r == h - 1)
            begin
                if (c >= 1)
                begin
                    if (c == 1) dx = (px(r, 1) - px(r, 0)) * 2;
                    else dx = px(r, c) - px(r, c - 2);
                    dy = (px(r, c - 1) - px(r - 1, c - 1)) * 2;
                    accumulate(r, c - 1, dx, dy, 1, 1'b0);
                end
                if (c == w - 1)
                begin
                    dx = (px(r, c) - px(r, c - 1)) * 2;
                    dy = (px(r, c) - px(r - 1, c)) * 2;
                    accumulate(r, c, dx, dy, 1, 1'b1);
                end
            end
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            row = r;
            col = c;
        endfunction

        function void report(string what, longint got, longint want);
            $display("mismatch %s: got %0h, want %0h", what, got, want);
            errors++;
        endfunction

        function void check_word(logic [TDATA_W-1:0] data, logic last);
            sums_word_t       w;
            logic [SUM_W-1:0] got;
            int               off;
            int               fw;
            if (pending_sums.size() == 0)
            begin
                report("unexpected word", longint'(data[SUM_W-1:0]), 0);
                return;
            end
            w = pending_sums.pop_front();
            off = 0;
            for (int k = 0; k < NCH; k++)
            begin
                fw = (k & 1) ? ABS_W : SUM_W;
                got = SUM_W'(data >> off) & ((SUM_W'(1) << fw) - 1);
                if (got !== w.sums[k]) report($sformatf("channel %0d", k), got, w.sums[k]);
                off += fw;
            end
            if (last !== w.last) report("tlast", last, w.last);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               cfg_we;
    logic               cfg_index;
    logic [10:0]        cfg_data;

    integral_tracker tracker;
    int              cycles;
    int              burst_left;
    bit              gaps_on;
    bit              hold_req;
    int              random_items;

    gradient_integral_image_8ch u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) tracker.check_word(m_tdata, m_tlast);
    end

    initial
    begin
        int mode;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                mode = (cycles / 97) % 3;
                if (mode == 0) m_tready <= 1'b1;
                else if (mode == 1) m_tready <= ($urandom_range(0, 9) < 7);
                else m_tready <= ((cycles % 11) < 4);
            end
        end
    end

    task automatic push_pixel(logic [7:0] pixel);
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if (gaps_on)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        forever
        begin
            @(posedge clk);
            if (s_tready) break;
        end
        tracker.take_pixel(pixel);
        random_items++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.pending_sums.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.write_reg(idx, value);
    endtask

    task automatic set_size(logic [10:0] w, logic [10:0] h);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    task automatic random_frames(int unsigned w, int unsigned h);
        int unsigned n;
        int          style;
        int          ramp;
        n = $urandom_range(1, 3) * tracker.clamp(w) * tracker.clamp(h);
        if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
        style = $urandom_range(0, 4);
        ramp = $urandom_range(0, 255);
        for (int unsigned i = 0; i < n && random_items < ITEMS; i++)
        begin
            case (style)
                0, 1: push_pixel(8'($urandom_range(0, 255)));
                2: push_pixel($urandom_range(0, 1) ? 8'hff : 8'h00);
                default:
                begin
                    ramp = (ramp + $urandom_range(0, 8) - 4) & 8'hff;
                    push_pixel(8'(ramp));
                end
            endcase
        end
    endtask

    initial
    begin
        logic [7:0] corner [24] = '{8'd0, 8'd255, 8'd255, 8'd0,
                                    8'd255, 8'd0, 8'd0, 8'd255,
                                    8'd255, 8'd255, 8'd255, 8'd255,
                                    8'd0, 8'd0, 8'd0, 8'd0,
                                    8'd0, 8'd255, 8'd0, 8'd255,
                                    8'd255, 8'd0, 8'd255, 8'd0};
        int unsigned w;
        int unsigned h;
        tracker      = new();
        cycles       = 0;
        burst_left   = 0;
        gaps_on      = 1'b0;
        hold_req     = 1'b0;
        random_items = 0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_WIDTH;
        cfg_data     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(posedge clk);

        // smallest frame, clamped from below: every sign pairing of the gradients
        set_size(11'd0, 11'd1);
        foreach (corner[i]) push_pixel(corner[i]);
        drain();

        // widest row, clamped from above
        gaps_on = 1'b1;
        set_size(11'd2047, 11'd2);
        for (int i = 0; i < 24; i++) push_pixel(8'($urandom_range(0, 255)));
        drain();

        // tallest frame at full height register, two columns; hold the output meanwhile
        hold_req = 1'b1;
        set_size(11'd2, 11'd1024);
        for (int i = 0; i < 40; i++) push_pixel(8'($urandom_range(0, 255)));
        drain();
        write_reg(CFG_WIDTH, 11'd1024);
        write_reg(CFG_HEIGHT, 11'd2);
        for (int i = 0; i < 12; i++) push_pixel(8'($urandom_range(0, 255)));
        drain();

        while (random_items < ITEMS)
        begin
            gaps_on = $urandom_range(0, 2) != 0;
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
            h = $urandom_range(1, 6);
            set_size(11'(w), 11'(h));
            random_frames(w, h);
            drain();
        end

        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
